// File: hw/rtl/brf_pkg.sv
package brf_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W = 6;
   localparam int COEF_N = 4;
   localparam int CSR_IDX_W = 2;
   localparam int FRAC_BITS_DEFAULT = 20;
   localparam int MAX_ITERATIONS_DEFAULT = 63;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUBIC    = 2'd0,
      CSR_SQUARE   = 2'd1,
      CSR_LINEAR   = 2'd2,
      CSR_CONSTANT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK             = 2'd0,
      STATUS_NO_SIGN_CHANGE = 2'd1,
      STATUS_BAD_COUNT      = 2'd2,
      STATUS_NO_BRACKET     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_LEFT,
      ST_EVAL_RIGHT,
      ST_CHECK,
      ST_MID,
      ST_MID_WAIT,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      HRN_IDLE,
      HRN_MUL,
      HRN_ADD
   } hrn_state_type;

   typedef logic signed [COEF_N-1:0][DATA_W-1:0] coef_array_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } sign_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] x;
   } hrn_req_type;

   typedef struct packed {
      logic     done;
      sign_type sign;
   } hrn_rsp_type;

endpackage

// File: hw/rtl/bisection_root_finder.sv
// Bisection root finder for a cubic p(x) = c3*x^3 + c2*x^2 + c1*x + c0 in signed
// fixed point with FRAC_BITS fraction bits.
// Coefficients are written through the csr_ channel (csr_index 0..3 selects c3..c0)
// while the block is idle, a rule left to the user to keep; csr_ready is always high.
// An item is taken on a clock edge where start is high and busy is low. It carries
// the step count and the interval ends. busy stays high until the result beat has
// been shown, so one item is worked on at a time.
// The result appears on the rsp_ ports for exactly one cycle with rsp_valid high.
// The receiver cannot stall; the beat must be taken in that cycle.
// Each polynomial evaluation runs on the one 32x32 multiplier: three multiply and
// three add passes of Horner's rule, with the result registered before it is reported.
// The result beat comes once every step has run, sooner when a midpoint hits the root
// or neither half is bracketed, and also sooner when the sign or count check fails.
// busy drops after the beat, so the next item can be taken in the cycle after it.
// Reset returns the coefficients to their default cubic and the sequencer to idle.
module bisection_root_finder #(
   parameter int FRAC_BITS      = brf_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_ITERATIONS = brf_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [5:0]          req_iterations,
   input  logic signed [31:0]  req_left_end,
   input  logic signed [31:0]  req_right_end,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_root_estimate,
   output logic signed [32:0]  rsp_error_bound,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic signed [31:0]  csr_data
);
   import brf_pkg::*;

   localparam logic signed [DATA_W-1:0] C3_RESET = DATA_W'(64'd1 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] C2_RESET =
      -DATA_W'(((64'd32 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [DATA_W-1:0] C1_RESET =
      DATA_W'(((64'd21 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [DATA_W-1:0] C0_RESET =
      DATA_W'(((64'd441 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITERATIONS);

   seq_state_type            state_ff, state_in;
   coef_array_type           coef_ff;
   logic signed [DATA_W-1:0] lo_ff, lo_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;
   logic signed [DATA_W-1:0] mid_ff, mid_in;
   sign_type                 lo_sign_ff, lo_sign_in;
   sign_type                 hi_sign_ff, hi_sign_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         steps_ff, steps_in;
   logic signed [DATA_W-1:0] root_ff, root_in;
   logic signed [DATA_W:0]   err_ff, err_in;
   status_type               status_ff, status_in;

   hrn_req_type              hrn_req;
   hrn_rsp_type              hrn_rsp;

   logic [CNT_W-1:0]         count_clamped;
   logic signed [DATA_W:0]   width_diff;
   logic signed [DATA_W:0]   mid_sum;
   logic signed [DATA_W-1:0] mid_now;
   sign_type                 msign;

   brf_horner #(
      .FRAC_BITS(FRAC_BITS)
   ) u_horner (
      .clock (clock),
      .reset (reset),
      .coef  (coef_ff),
      .req   (hrn_req),
      .rsp   (hrn_rsp)
   );

   assign count_clamped = (req_iterations > MAX_CNT) ? MAX_CNT : req_iterations;
   assign width_diff    = (DATA_W+1)'(req_right_end) - (DATA_W+1)'(req_left_end);
   assign mid_sum       = (DATA_W+1)'(lo_ff) + (DATA_W+1)'(hi_ff);
   assign mid_now       = mid_sum[DATA_W:1];
   assign msign         = hrn_rsp.sign;

   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      lo_sign_in  = lo_sign_ff;
      hi_sign_in  = hi_sign_ff;
      count_in    = count_ff;
      steps_in    = steps_ff;
      root_in     = root_ff;
      err_in      = err_ff;
      status_in   = status_ff;
      hrn_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lo_in       = req_left_end;
               hi_in       = req_right_end;
               count_in    = count_clamped;
               err_in      = width_diff >>> count_clamped;
               root_in     = '0;
               status_in   = STATUS_OK;
               hrn_req.start = 1'b1;
               hrn_req.x     = req_left_end;
               state_in    = ST_EVAL_LEFT;
            end
         end
         ST_EVAL_LEFT: begin
            if (hrn_rsp.done) begin
               lo_sign_in    = msign;
               hrn_req.start = 1'b1;
               hrn_req.x     = hi_ff;
               state_in      = ST_EVAL_RIGHT;
            end
         end
         ST_EVAL_RIGHT: begin
            if (hrn_rsp.done) begin
               hi_sign_in = msign;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!lo_sign_ff.zero && !hi_sign_ff.zero &&
                (lo_sign_ff.neg == hi_sign_ff.neg)) begin
               status_in = STATUS_NO_SIGN_CHANGE;
               state_in  = ST_DONE;
            end else if (count_ff == '0) begin
               status_in = STATUS_BAD_COUNT;
               state_in  = ST_DONE;
            end else begin
               steps_in = count_ff;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (steps_ff == CNT_W'(1)) begin
               root_in  = mid_now;
               state_in = ST_DONE;
            end else begin
               mid_in        = mid_now;
               hrn_req.start = 1'b1;
               hrn_req.x     = mid_now;
               state_in      = ST_MID_WAIT;
            end
         end
         ST_MID_WAIT: begin
            if (hrn_rsp.done) begin
               // Keep the half whose ends show a strict sign change.
               if (!lo_sign_ff.zero && !msign.zero && (msign.neg != lo_sign_ff.neg)) begin
                  hi_in      = mid_ff;
                  hi_sign_in = msign;
                  steps_in   = steps_ff - CNT_W'(1);
                  state_in   = ST_MID;
               end else if (!msign.zero && !hi_sign_ff.zero &&
                            (hi_sign_ff.neg != msign.neg)) begin
                  lo_in      = mid_ff;
                  lo_sign_in = msign;
                  steps_in   = steps_ff - CNT_W'(1);
                  state_in   = ST_MID;
               end else if (msign.zero) begin
                  root_in  = mid_ff;
                  state_in = ST_DONE;
               end else begin
                  status_in = STATUS_NO_BRACKET;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         lo_ff      <= '0;
         hi_ff      <= '0;
         steps_ff   <= '0;
         lo_sign_ff <= '0;
      end else begin
         state_ff   <= state_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         steps_ff   <= steps_in;
         lo_sign_ff <= lo_sign_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff     <= mid_in;
      hi_sign_ff <= hi_sign_in;
      count_ff   <= count_in;
      root_ff    <= root_in;
      err_ff     <= err_in;
      status_ff  <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_CUBIC]    <= C3_RESET;
         coef_ff[CSR_SQUARE]   <= C2_RESET;
         coef_ff[CSR_LINEAR]   <= C1_RESET;
         coef_ff[CSR_CONSTANT] <= C0_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CUBIC:    coef_ff[CSR_CUBIC]    <= csr_data;
            CSR_SQUARE:   coef_ff[CSR_SQUARE]   <= csr_data;
            CSR_LINEAR:   coef_ff[CSR_LINEAR]   <= csr_data;
            CSR_CONSTANT: coef_ff[CSR_CONSTANT] <= csr_data;
            default:      coef_ff[CSR_CUBIC]    <= coef_ff[CSR_CUBIC];
         endcase
      end
   end

   assign csr_ready         = 1'b1;
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_root_estimate = root_ff;
   assign rsp_error_bound   = err_ff;
   assign rsp_status        = status_ff;

`ifndef SYNTH
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat outside a busy period");

   a_rsp_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result beat not followed by idle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not start work");

   a_mid_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID_WAIT) |-> (steps_ff > CNT_W'(1)))
      else $error("midpoint evaluated on the last step");

   a_horner_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      hrn_rsp.done |-> (state_ff == ST_EVAL_LEFT || state_ff == ST_EVAL_RIGHT ||
                        state_ff == ST_MID_WAIT))
      else $error("polynomial result arrived with nobody waiting");
`endif

endmodule

// File: hw/rtl/brf_horner.sv
module brf_horner #(
   parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  brf_pkg::coef_array_type coef,
   input  brf_pkg::hrn_req_type    req,
   output brf_pkg::hrn_rsp_type    rsp
);
   import brf_pkg::*;

   localparam int PROD_W = 2 * DATA_W;

   hrn_state_type            state_ff, state_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]               step_ff, step_in;
   logic                     done_ff, done_in;

   logic signed [DATA_W-1:0] coef_sel;
   logic signed [PROD_W-1:0] sum;
   logic signed [DATA_W-1:0] sum_sat;

   always_comb begin
      case (step_ff)
         2'd0:    coef_sel = coef[CSR_SQUARE];
         2'd1:    coef_sel = coef[CSR_LINEAR];
         default: coef_sel = coef[CSR_CONSTANT];
      endcase
   end

   // The arithmetic shift of the product floors toward minus infinity.
   assign sum = (prod_ff >>> FRAC_BITS) + PROD_W'(coef_sel);

   always_comb begin
      if (!sum[PROD_W-1] && (|sum[PROD_W-2:DATA_W-1])) begin
         sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sum[PROD_W-1] && !(&sum[PROD_W-2:DATA_W-1])) begin
         sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sum_sat = sum[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         HRN_IDLE: begin
            if (req.start) begin
               x_in     = req.x;
               acc_in   = coef[CSR_CUBIC];
               step_in  = 2'd0;
               state_in = HRN_MUL;
            end
         end
         HRN_MUL: begin
            prod_in  = acc_ff * x_ff;
            state_in = HRN_ADD;
         end
         HRN_ADD: begin
            acc_in = sum_sat;
            if (step_ff == 2'd2) begin
               done_in  = 1'b1;
               state_in = HRN_IDLE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = HRN_MUL;
            end
         end
         default: begin
            state_in = HRN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HRN_IDLE;
         step_ff  <= 2'd0;
         done_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.sign.zero = (acc_ff == '0);
   assign rsp.sign.neg  = acc_ff[DATA_W-1];

endmodule

// File: tb/bisection_root_finder_checker.sv
`timescale 1ns / 100ps

module bisection_root_finder_checker #(
   parameter int FRAC_BITS      = brf_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_ITERATIONS = brf_pkg::MAX_ITERATIONS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [5:0]         req_iterations,
   input  logic signed [31:0] req_left_end,
   input  logic signed [31:0] req_right_end,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_root_estimate,
   input  logic signed [32:0] rsp_error_bound,
   input  logic [1:0]         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic signed [31:0] csr_data,
   output int                 roots_pending,
   output int                 results_checked,
   output int                 converged_count,
   output int                 mismatch_count
);

   localparam longint DEFAULT_CUBIC    = 1048576;
   localparam longint DEFAULT_SQUARE   = -3355443;
   localparam longint DEFAULT_LINEAR   = 220201;
   localparam longint DEFAULT_CONSTANT = 4624220;
   localparam int     PRINT_LIMIT      = 40;

   typedef struct packed {
      logic signed [31:0]  root;
      logic signed [32:0]  bound;
      brf_pkg::status_type status;
   } bisection_answer_t;

   longint            coefficient [brf_pkg::COEF_N];
   bisection_answer_t predicted_roots [$];

   function automatic longint clamp_word(longint value);
      if (value > 64'sd2147483647)
         return 64'sd2147483647;
      if (value < -64'sd2147483648)
         return -64'sd2147483648;
      return value;
   endfunction

   // Horner's rule; each product is floored back to the fixed-point scale.
   function automatic longint eval_cubic(longint x);
      longint acc;
      acc = coefficient[brf_pkg::CSR_CUBIC];
      acc = clamp_word(((acc * x) >>> FRAC_BITS) + coefficient[brf_pkg::CSR_SQUARE]);
      acc = clamp_word(((acc * x) >>> FRAC_BITS) + coefficient[brf_pkg::CSR_LINEAR]);
      acc = clamp_word(((acc * x) >>> FRAC_BITS) + coefficient[brf_pkg::CSR_CONSTANT]);
      return acc;
   endfunction

   function automatic int sign_of(longint value);
      return (value > 0) ? 1 : ((value < 0) ? -1 : 0);
   endfunction

   function automatic bisection_answer_t solve_by_bisection(logic [5:0] count,
                                                            logic signed [31:0] left_end,
                                                            logic signed [31:0] right_end);
      bisection_answer_t answer;
      int                steps;
      longint            lo;
      longint            hi;
      longint            mid;
      longint            shifted;
      int                lo_sign;
      int                hi_sign;
      int                mid_sign;
      bit                done;
      steps = count;
      if (steps > MAX_ITERATIONS)
         steps = MAX_ITERATIONS;
      lo = left_end;
      hi = right_end;
      shifted = (hi - lo) >>> steps;
      answer.root = '0;
      answer.bound = shifted[32:0];
      answer.status = brf_pkg::STATUS_OK;
      lo_sign = sign_of(eval_cubic(lo));
      hi_sign = sign_of(eval_cubic(hi));
      if (lo_sign != 0 && lo_sign == hi_sign) begin
         answer.status = brf_pkg::STATUS_NO_SIGN_CHANGE;
      end else if (steps == 0) begin
         answer.status = brf_pkg::STATUS_BAD_COUNT;
      end else begin
         done = 1'b0;
         while (!done) begin
            mid = (lo + hi) >>> 1;
            if (steps == 1) begin
               answer.root = mid[31:0];
               done = 1'b1;
            end else begin
               mid_sign = sign_of(eval_cubic(mid));
               if (lo_sign != 0 && mid_sign == -lo_sign) begin
                  hi = mid;
                  hi_sign = mid_sign;
               end else if (mid_sign != 0 && hi_sign == -mid_sign) begin
                  lo = mid;
                  lo_sign = mid_sign;
               end else if (mid_sign == 0) begin
                  // The midpoint hit the root exactly, so it is returned as is.
                  answer.root = mid[31:0];
                  done = 1'b1;
               end else begin
                  answer.status = brf_pkg::STATUS_NO_BRACKET;
                  done = 1'b1;
               end
               steps--;
            end
         end
      end
      return answer;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
   endtask

   task automatic check_result_beat();
      bisection_answer_t want;
      if (predicted_roots.size() == 0) begin
         report_mismatch("unrequested result beat", rsp_root_estimate, 0);
      end else begin
         want = predicted_roots.pop_front();
         results_checked++;
         if (want.status == brf_pkg::STATUS_OK)
            converged_count++;
         if (rsp_root_estimate !== want.root)
            report_mismatch("root_estimate", rsp_root_estimate, want.root);
         if (rsp_error_bound !== want.bound)
            report_mismatch("error_bound", rsp_error_bound, want.bound);
         if (rsp_status !== want.status)
            report_mismatch("status", rsp_status, want.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coefficient[brf_pkg::CSR_CUBIC] = DEFAULT_CUBIC;
         coefficient[brf_pkg::CSR_SQUARE] = DEFAULT_SQUARE;
         coefficient[brf_pkg::CSR_LINEAR] = DEFAULT_LINEAR;
         coefficient[brf_pkg::CSR_CONSTANT] = DEFAULT_CONSTANT;
         predicted_roots.delete();
      end else begin
         // A result beat belongs to an older item than one accepted on the same edge.
         if (rsp_valid)
            check_result_beat();
         if (start && !busy)
            predicted_roots.push_back(solve_by_bisection(req_iterations, req_left_end,
                                                         req_right_end));
         if (csr_valid && csr_ready)
            coefficient[csr_index] = longint'(csr_data);
      end
      roots_pending = predicted_roots.size();
   end

endmodule

// File: tb/bisection_root_finder_tb.sv
`timescale 1ns / 100ps

module bisection_root_finder_tb;
   import brf_pkg::*;

   localparam int UNIT = 1 << FRAC_BITS_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_ITEMS_PER_SET = 88;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [5:0]         req_iterations = '0;
   logic signed [31:0] req_left_end = '0;
   logic signed [31:0] req_right_end = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_root_estimate;
   logic signed [32:0] rsp_error_bound;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = CSR_CUBIC;
   logic signed [31:0] csr_data = '0;

   int roots_pending;
   int results_checked;
   int converged_count;
   int mismatch_count;
   int items_sent = 0;
   int register_writes = 0;
   int sender_idle_pct = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   bisection_root_finder DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_iterations    (req_iterations),
      .req_left_end      (req_left_end),
      .req_right_end     (req_right_end),
      .rsp_valid         (rsp_valid),
      .rsp_root_estimate (rsp_root_estimate),
      .rsp_error_bound   (rsp_error_bound),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   bisection_root_finder_checker CHECKER (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_iterations    (req_iterations),
      .req_left_end      (req_left_end),
      .req_right_end     (req_right_end),
      .rsp_valid         (rsp_valid),
      .rsp_root_estimate (rsp_root_estimate),
      .rsp_error_bound   (rsp_error_bound),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .roots_pending     (roots_pending),
      .results_checked   (results_checked),
      .converged_count   (converged_count),
      .mismatch_count    (mismatch_count)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("No beat moved for %0d cycles.", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // Start is left high after the beat so that a following item needs no second
   // assignment in the same step; the caller lowers it at the end of a burst.
   task automatic send_item(logic [5:0] count, logic signed [31:0] left_end,
                            logic signed [31:0] right_end);
      bit taken;
      req_iterations <= count;
      req_left_end <= left_end;
      req_right_end <= right_end;
      start <= ($urandom_range(99) >= sender_idle_pct);
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = start && !busy;
         if (!taken)
            start <= ($urandom_range(99) >= sender_idle_pct);
      end
      items_sent++;
   endtask

   task automatic send_random_item();
      logic [5:0]         count;
      logic signed [31:0] a;
      logic signed [31:0] b;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 8)
         count = '0;
      else if (pick < 78)
         count = 6'($urandom_range(16, 1));
      else
         count = 6'($urandom_range(63, 17));
      pick = $urandom_range(99);
      a = $urandom_range(12 * UNIT) - 6 * UNIT;
      b = $urandom_range(12 * UNIT) - 6 * UNIT;
      if (pick < 10) begin
         a = $urandom;
         b = $urandom;
      end else begin
         // Mostly ordered intervals near the roots, some reversed ones.
         if ((pick < 85) == (a > b))
            {a, b} = {b, a};
         if (pick >= 93) begin
            if (pick[0])
               a = '0;
            else
               b = '0;
         end
      end
      send_item(count, a, b);
   endtask

   task automatic write_coefficient(csr_index_type index, logic signed [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      register_writes++;
   endtask

   task automatic load_coefficients(logic signed [31:0] c3, logic signed [31:0] c2,
                                    logic signed [31:0] c1, logic signed [31:0] c0);
      write_coefficient(CSR_CUBIC, c3);
      write_coefficient(CSR_SQUARE, c2);
      write_coefficient(CSR_LINEAR, c1);
      write_coefficient(CSR_CONSTANT, c0);
      csr_valid <= 1'b0;
   endtask

   // Expands a cubic from three random roots within +-4.0 so that random intervals
   // often bracket one of them.
   task automatic load_cubic_from_roots();
      longint r1;
      longint r2;
      longint r3;
      longint c3;
      longint c2;
      longint c1;
      longint c0;
      r1 = longint'($urandom_range(8 * UNIT)) - 4 * UNIT;
      r2 = longint'($urandom_range(8 * UNIT)) - 4 * UNIT;
      r3 = longint'($urandom_range(8 * UNIT)) - 4 * UNIT;
      c3 = UNIT;
      c2 = -(r1 + r2 + r3);
      c1 = (r1 * r2 + r1 * r3 + r2 * r3) >>> FRAC_BITS_DEFAULT;
      c0 = -((((r1 * r2) >>> FRAC_BITS_DEFAULT) * r3) >>> FRAC_BITS_DEFAULT);
      if ($urandom_range(1) == 1) begin
         c3 = -c3;
         c2 = -c2;
         c1 = -c1;
         c0 = -c0;
      end
      load_coefficients(c3[31:0], c2[31:0], c1[31:0], c0[31:0]);
   endtask

   task automatic settle_block();
      @(negedge clock);
      while (roots_pending != 0 || busy)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic end_burst();
      start <= 1'b0;
      settle_block();
   endtask

   initial begin
      int phase;
      int set;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 10;

      // The reset cubic is (x + 1)(x - 2.1)^2: one simple root and one double root.
      send_item(20, -2 * UNIT, 0);
      send_item(20, UNIT, 3 * UNIT);
      send_item(0, -2 * UNIT, 0);
      send_item(0, UNIT, 3 * UNIT);
      send_item(1, -2 * UNIT, 0);
      send_item(63, -2 * UNIT, 0);
      send_item(63, WORD_MIN, WORD_MAX);
      send_item(16, 0, -2 * UNIT);
      send_item(5, WORD_MAX, WORD_MIN);
      send_item(40, WORD_MIN, WORD_MIN);
      send_item(17, WORD_MAX, WORD_MAX);
      end_burst();

      // With p(x) = x, zero ends and an exact midpoint root are easy to hit.
      load_coefficients(0, 0, UNIT, 0);
      send_item(10, -UNIT, UNIT);
      send_item(10, 0, UNIT);
      send_item(10, -UNIT, 0);
      send_item(8, 0, 0);
      send_item(1, 0, 0);
      end_burst();

      load_coefficients(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_item(10, WORD_MIN, WORD_MAX);
      send_item(5, -UNIT, UNIT);
      end_burst();
      load_coefficients(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_item(10, WORD_MIN, WORD_MAX);
      send_item(5, -UNIT, UNIT);
      end_burst();

      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 10 : ((phase == 1) ? 72 : 0);
         for (set = 0; set < 2; set++) begin
            if (phase == 0 && set == 0)
               load_coefficients(UNIT, -3355443, 220201, 4624220);
            else
               load_cubic_from_roots();
            repeat (RANDOM_ITEMS_PER_SET) send_random_item();
            end_burst();
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d root searches over ten coefficient sets, %0d register writes.",
               items_sent, register_writes);
      $display("Checked %0d results, %0d of them found a root.", results_checked,
               converged_count);
      if (mismatch_count == 0 && roots_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
